### rtl/core/palr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the palette resampling interpolator.
// Used by every module of the block but palr_ram; depends on nothing.
package palr_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_LEVELS    = 4096;
    localparam int IDX_W         = 8;
    localparam int LEVEL_W       = 12;
    localparam int CH_W          = 8;
    localparam int COLOR_W       = 3 * CH_W;
    localparam int NUM_W         = 20;
    localparam int DIVD_W        = 21;
    localparam int CFG_DATA_W    = 13;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = 2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_PALETTE_COUNT = 1'b0;
    localparam logic CFG_LEVEL_COUNT   = 1'b1;

    typedef struct packed {
        logic               command;
        logic [IDX_W-1:0]   entry_index;
        logic [CH_W-1:0]    entry_red;
        logic [CH_W-1:0]    entry_green;
        logic [CH_W-1:0]    entry_blue;
        logic [LEVEL_W-1:0] level_index;
    } in_item_t;

    typedef struct packed {
        logic [CH_W-1:0] out_red;
        logic [CH_W-1:0] out_green;
        logic [CH_W-1:0] out_blue;
        logic            level_clipped;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]   pmax;
        logic [LEVEL_W-1:0] lmax;
    } span_t;

    typedef struct packed {
        logic               is_write;
        logic               last;
        logic               clipped;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] color;
        logic [NUM_W-1:0]   rem;
        logic [IDX_W-1:0]   quo;
    } div_stage_t;

    typedef struct packed {
        logic               is_write;
        logic [IDX_W-1:0]   addr;
        logic [COLOR_W-1:0] color;
        logic               clipped;
        logic [LEVEL_W-1:0] rem;
    } queue_item_t;

endpackage

### rtl/core/palette_resample_interpolator.sv
`timescale 1ns / 1ps
// Palette resampling interpolator: one beat per cycle in unless in_stall is high,
// one result per query out. An accepted query passes the front divider (eight
// stages), the queue and the back blend and divider. Throughput is one beat per
// cycle while in_stall is low. Reset is asynchronous and clears all control
// state; the palette store is undefined until written. Depends on palr_pkg.
module palette_resample_interpolator (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  palr_pkg::in_item_t                 in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output palr_pkg::out_item_t                out_data,
    input  logic                               cfg_we,
    input  logic                               cfg_index,
    input  logic [palr_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [8:0]                     palette_count_reg;
    logic [palr_pkg::CFG_DATA_W-1:0] level_count_reg;
    logic [8:0]                     pc;
    logic [palr_pkg::CFG_DATA_W-1:0] lc;
    palr_pkg::span_t                span;
    logic                           q_push;
    logic                           q_ready;
    logic                           q_pop;
    logic                           q_valid;
    palr_pkg::queue_item_t          q_in;
    palr_pkg::queue_item_t          q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            palette_count_reg <= 9'd2;
            level_count_reg   <= 13'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                palr_pkg::CFG_PALETTE_COUNT: palette_count_reg <= cfg_data[8:0];
                palr_pkg::CFG_LEVEL_COUNT:   level_count_reg   <= cfg_data;
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        pc = palette_count_reg;
        if (palette_count_reg < 9'd2)
        begin
            pc = 9'd2;
        end
        else if (palette_count_reg > 9'(palr_pkg::PALETTE_DEPTH))
        begin
            pc = 9'(palr_pkg::PALETTE_DEPTH);
        end
        lc = level_count_reg;
        if (level_count_reg < 13'd2)
        begin
            lc = 13'd2;
        end
        else if (level_count_reg > 13'(palr_pkg::MAX_LEVELS))
        begin
            lc = 13'(palr_pkg::MAX_LEVELS);
        end
        span.pmax = 8'(pc - 9'd1);
        span.lmax = 12'(lc - 13'd1);
    end

    palr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .span     (span),
        .q_push   (q_push),
        .q_ready  (q_ready),
        .q_data   (q_in)
    );

    palr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .ready     (q_ready),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    palr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .span      (span),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

### rtl/core/palr_ram.sv
`timescale 1ns / 1ps
// Generic RAM with one write port and two registered read ports.
// Depends on nothing.
module palr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### rtl/core/palr_front.sv
`timescale 1ns / 1ps
// Front end: accepts beats, classifies them and finds the palette segment
// with a pipelined restoring divider. Depends on palr_pkg.
module palr_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  palr_pkg::in_item_t    in_data,
    input  palr_pkg::span_t       span,
    output logic                  q_push,
    input  logic                  q_ready,
    output palr_pkg::queue_item_t q_data
);

    localparam int NDIV = palr_pkg::IDX_W;

    logic                 adv;
    logic                 s0_vld_reg;
    palr_pkg::in_item_t   s0_item_reg;
    logic [NDIV:0]        vld_reg;
    palr_pkg::div_stage_t st_reg  [0:NDIV];
    palr_pkg::div_stage_t st_next [0:NDIV];
    logic [palr_pkg::NUM_W-1:0] trial [1:NDIV];

    assign adv      = !(vld_reg[NDIV] && !q_ready);
    assign in_stall = !adv;
    assign q_push   = vld_reg[NDIV] && q_ready;

    always_comb
    begin
        st_next[0].is_write = (s0_item_reg.command == palr_pkg::CMD_WRITE);
        st_next[0].last     = (s0_item_reg.level_index >= span.lmax);
        st_next[0].clipped  = (s0_item_reg.level_index > span.lmax);
        st_next[0].addr     = st_next[0].is_write ? s0_item_reg.entry_index : span.pmax;
        st_next[0].color    = {s0_item_reg.entry_red, s0_item_reg.entry_green,
                               s0_item_reg.entry_blue};
        st_next[0].rem      = st_next[0].last ? '0 :
                              palr_pkg::NUM_W'(span.pmax) *
                              palr_pkg::NUM_W'(s0_item_reg.level_index);
        st_next[0].quo      = '0;
        for (int j = 1; j <= NDIV; j++)
        begin
            st_next[j] = st_reg[j-1];
            trial[j]   = palr_pkg::NUM_W'(span.lmax) << (NDIV - j);
            if (st_reg[j-1].rem >= trial[j])
            begin
                st_next[j].rem         = st_reg[j-1].rem - trial[j];
                st_next[j].quo[NDIV-j] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            vld_reg    <= '0;
        end
        else if (adv)
        begin
            s0_vld_reg <= in_valid;
            vld_reg    <= {vld_reg[NDIV-1:0], s0_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_item_reg <= in_data;
            for (int j = 0; j <= NDIV; j++)
            begin
                st_reg[j] <= st_next[j];
            end
        end
    end

    always_comb
    begin
        q_data.is_write = st_reg[NDIV].is_write;
        q_data.addr     = (st_reg[NDIV].is_write || st_reg[NDIV].last) ?
                          st_reg[NDIV].addr : st_reg[NDIV].quo;
        q_data.color    = st_reg[NDIV].color;
        q_data.clipped  = st_reg[NDIV].clipped;
        q_data.rem      = st_reg[NDIV].rem[palr_pkg::LEVEL_W-1:0];
    end

endmodule

### rtl/core/palr_queue.sv
`timescale 1ns / 1ps
// Short register queue between the front end and the back end.
// Depends on palr_pkg.
module palr_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  palr_pkg::queue_item_t push_data,
    output logic                  ready,
    input  logic                  pop,
    output logic                  valid,
    output palr_pkg::queue_item_t head
);

    palr_pkg::queue_item_t         slot_reg [palr_pkg::QUEUE_DEPTH];
    logic [palr_pkg::QPTR_W-1:0]   wr_reg;
    logic [palr_pkg::QPTR_W-1:0]   rd_reg;
    logic [palr_pkg::QPTR_W:0]     cnt_reg;
    logic [palr_pkg::QPTR_W:0]     cnt_next;

    assign valid = (cnt_reg != '0);
    assign ready = (cnt_reg != (palr_pkg::QPTR_W+1)'(palr_pkg::QUEUE_DEPTH)) || pop;
    assign head  = slot_reg[rd_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/palr_back.sv
`timescale 1ns / 1ps
// Back end: palette store access, per-channel blend and rounding division.
// Depends on palr_pkg and palr_ram.
module palr_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_pop,
    input  palr_pkg::queue_item_t q_head,
    input  palr_pkg::span_t       span,
    output logic                  out_valid,
    input  logic                  out_stall,
    output palr_pkg::out_item_t   out_data
);

    localparam int NDIV = palr_pkg::CH_W;
    localparam int CW   = palr_pkg::CH_W;
    localparam int DW   = palr_pkg::DIVD_W;

    logic                             adv;
    logic [palr_pkg::COLOR_W-1:0]     rd_a;
    logic [palr_pkg::COLOR_W-1:0]     rd_b;
    logic                             v1_reg;
    logic                             v2_reg;
    logic [NDIV:0]                    vd_reg;
    logic                             clip1_reg;
    logic [palr_pkg::LEVEL_W-1:0]     rem1_reg;
    logic                             clip2_reg;
    logic [palr_pkg::NUM_W-1:0]       p0_reg [0:2];
    logic signed [palr_pkg::NUM_W+1:0] p1_reg [0:2];
    logic [NDIV:0]                    clipd_reg;
    logic [DW-1:0]                    dr_reg  [0:NDIV][0:2];
    logic [CW-1:0]                    dq_reg  [0:NDIV][0:2];
    logic [DW-1:0]                    dr_next [0:NDIV][0:2];
    logic [CW-1:0]                    dq_next [0:NDIV][0:2];
    logic [CW-1:0]                    c0 [0:2];
    logic [CW-1:0]                    c1 [0:2];
    logic signed [CW:0]               diff [0:2];
    logic signed [palr_pkg::NUM_W+1:0] sum [0:2];
    logic [DW-1:0]                    trial [1:NDIV];

    assign adv   = !(out_valid && out_stall);
    assign q_pop = adv && q_valid;

    // With no fractional part the upper entry does not contribute, so the same
    // entry is read twice; this keeps the last level clear of the slot above it.
    palr_ram #(
        .WIDTH (palr_pkg::COLOR_W),
        .DEPTH (palr_pkg::PALETTE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (q_pop && q_head.is_write),
        .waddr   (q_head.addr),
        .wdata   (q_head.color),
        .re      (adv),
        .raddr_a (q_head.addr),
        .raddr_b ((q_head.rem == '0) ? q_head.addr : q_head.addr + 1'b1),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            c0[c]   = rd_a[c*CW +: CW];
            c1[c]   = rd_b[c*CW +: CW];
            diff[c] = $signed({1'b0, c1[c]}) - $signed({1'b0, c0[c]});
            sum[c]  = $signed({2'b00, p0_reg[c]}) + p1_reg[c];
            dr_next[0][c] = DW'({sum[c][palr_pkg::NUM_W-1:0], 1'b0}) + DW'(span.lmax);
            dq_next[0][c] = '0;
        end
        for (int j = 1; j <= NDIV; j++)
        begin
            trial[j] = DW'({span.lmax, 1'b0}) << (NDIV - j);
            for (int c = 0; c < 3; c++)
            begin
                dr_next[j][c] = dr_reg[j-1][c];
                dq_next[j][c] = dq_reg[j-1][c];
                if (dr_reg[j-1][c] >= trial[j])
                begin
                    dr_next[j][c]         = dr_reg[j-1][c] - trial[j];
                    dq_next[j][c][NDIV-j] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vd_reg <= '0;
        end
        else if (adv)
        begin
            v1_reg <= q_pop && !q_head.is_write;
            v2_reg <= v1_reg;
            vd_reg <= {vd_reg[NDIV-1:0], v2_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            clip1_reg <= q_head.clipped;
            rem1_reg  <= q_head.rem;
            clip2_reg <= clip1_reg;
            clipd_reg <= {clipd_reg[NDIV-1:0], clip2_reg};
            for (int c = 0; c < 3; c++)
            begin
                p0_reg[c] <= palr_pkg::NUM_W'(c0[c]) * palr_pkg::NUM_W'(span.lmax);
                p1_reg[c] <= (palr_pkg::NUM_W+2)'($signed({1'b0, rem1_reg}) * diff[c]);
            end
            for (int j = 0; j <= NDIV; j++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    dr_reg[j][c] <= dr_next[j][c];
                    dq_reg[j][c] <= dq_next[j][c];
                end
            end
        end
    end

    assign out_valid              = vd_reg[NDIV];
    assign out_data.out_red       = dq_reg[NDIV][2];
    assign out_data.out_green     = dq_reg[NDIV][1];
    assign out_data.out_blue      = dq_reg[NDIV][0];
    assign out_data.level_clipped = clipd_reg[NDIV];

endmodule

### rtl/core/palr_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the palette resampling interpolator, bound to the top level.
// Depends on palr_pkg.
module palr_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_stall,
    input palr_pkg::in_item_t              in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input palr_pkg::out_item_t             out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input beat changed while stalled");

    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid && !in_stall)
        else $error("activity straight after reset");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while the output side moves");

endmodule

bind palette_resample_interpolator palr_checker u_checker (.*);
